[hw/rtl/temperature_seven_segment_display_unit_assert.svh]
// Assertion helpers for the display unit
`ifndef TEMPERATURE_SEVEN_SEGMENT_DISPLAY_UNIT_ASSERT_SVH
`define TEMPERATURE_SEVEN_SEGMENT_DISPLAY_UNIT_ASSERT_SVH

// same-cycle implication
`define TSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsd assertion failed");

// next-cycle implication
`define TSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsd assertion failed");

`endif

[hw/rtl/tsd_pkg.sv]
`default_nettype none
package tsd_pkg;

	localparam int SCAN_DIGITS_DEF = 6;
	localparam int POS_W           = 3;
	localparam int STORE_DIGITS    = 5;
	localparam int VAL_W           = 14;

	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [7:0]           seg_t;
	typedef logic signed [11:0]   temp_t;
	typedef logic [VAL_W-1:0]     val_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef struct packed {
		logic [3:0] digit;
		val_t       rem;
	} split_t;

	localparam pos_t POINT_POS     = 3'd2;
	localparam seg_t MINUS_PATTERN = 8'h40;
	localparam seg_t POINT_BIT     = 8'h80;
	localparam val_t MOD_VALUE     = 14'd10000;

	function automatic seg_t seg_code(input logic [3:0] d);
		seg_t s;
		unique case (d)
			4'd0:    s = 8'h3f;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5b;
			4'd3:    s = 8'h4f;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6d;
			4'd6:    s = 8'h7d;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7f;
			4'd9:    s = 8'h6f;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	// leading decimal digit of value for a constant weight, value < 10 * weight
	function automatic split_t split_digit(input val_t value, input val_t weight);
		split_t r;
		r.digit = 4'd0;
		r.rem   = value;
		for (int k = 1; k <= 9; k++) begin
			if (value >= VAL_W'(k) * weight) begin
				r.digit = 4'(k);
				r.rem   = value - VAL_W'(k) * weight;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/tsd_if.sv]
`default_nettype none
interface tsd_item_if;
	import tsd_pkg::*;

	logic  valid;
	logic  ready;
	op_t   op;
	temp_t raw_temp;

	modport source (output valid, output op, output raw_temp, input ready);
	modport sink   (input valid, input op, input raw_temp, output ready);
endinterface

interface tsd_result_if;
	import tsd_pkg::*;

	logic valid;
	logic ready;
	seg_t segments;
	pos_t digit_select;
	pos_t scan_position;

	modport source (output valid, output segments, output digit_select,
		output scan_position, input ready);
	modport sink   (input valid, input segments, input digit_select,
		input scan_position, output ready);
endinterface
`default_nettype wire

[hw/rtl/temperature_seven_segment_display_unit.sv]
// channel  | dir | payload                                  | transaction
// ---------+-----+------------------------------------------+---------------------------
// item     | in  | op, raw_temp (s12, 1/16 deg)             | sample or scan tick
// result   | out | segments, digit_select, scan_position    | one per tick, none per sample
//
// Takes one transaction per cycle while item.ready is high. Four compute stages
// (magnitude and mod 10000, thousands, hundreds, then tens and units) feed the digit
// store and the output register; a tick passes stages 1 to 4, then sets result.valid.
// arst_n clears stage valids, the digit store (blank), the scan position and result.valid.
// A stalled result only holds the stages behind it; bubbles in the pipe still close up.
`default_nettype none
`include "temperature_seven_segment_display_unit_assert.svh"
module temperature_seven_segment_display_unit #(
	parameter int SCAN_DIGITS = tsd_pkg::SCAN_DIGITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tsd_item_if.sink     item,
	tsd_result_if.source result
);
	import tsd_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	op_t  op_s1, op_s2, op_s3, op_s4;
	temp_t raw_s1;
	logic neg_s2, neg_s3, neg_s4;
	val_t v_s2, rem_s3, rem_s4;
	logic [3:0] thou_s3, thou_s4, hund_s4;

	seg_t store_q [STORE_DIGITS];
	pos_t scan_q;
	seg_t seg_q;
	pos_t dsel_q, spos_q;

	logic free_out, mv1, mv2, mv3, mv4, take;
	logic commit_sample, commit_tick;
	logic neg_w;
	logic [11:0] mag_w;
	logic [15:0] h_w;
	val_t hv_w, v_w;
	split_t thou_w, hund_w, tens_w;
	logic [POS_W:0] pos_inc_w;
	logic wrap_w;
	seg_t tick_seg_w;

	always_comb begin
		free_out      = !out_valid_q || result.ready;
		mv4           = valid_s4 && (op_s4 == OP_SAMPLE || free_out);
		mv3           = valid_s3 && (!valid_s4 || mv4);
		mv2           = valid_s2 && (!valid_s3 || mv3);
		mv1           = valid_s1 && (!valid_s2 || mv2);
		take          = item.valid && item.ready;
		commit_sample = mv4 && op_s4 == OP_SAMPLE;
		commit_tick   = mv4 && op_s4 == OP_TICK;
	end

	assign item.ready = !valid_s1 || mv1;

	// magnitude, hundredths rounded half up, mod 10000
	always_comb begin
		neg_w = raw_s1[11];
		mag_w = neg_w ? (~$unsigned(raw_s1) + 12'd1) : $unsigned(raw_s1);
		h_w   = ({4'd0, mag_w} * 16'd25 + 16'd2) >> 2;
		hv_w  = h_w[VAL_W-1:0];
		v_w   = (hv_w >= MOD_VALUE) ? hv_w - MOD_VALUE : hv_w;
	end

	always_comb begin
		thou_w = split_digit(v_s2, 14'd1000);
		hund_w = split_digit(rem_s3, 14'd100);
		tens_w = split_digit(rem_s4, 14'd10);
	end

	always_comb begin
		pos_inc_w  = {1'b0, scan_q} + 4'd1;
		wrap_w     = pos_inc_w >= (POS_W+1)'(SCAN_DIGITS);
		tick_seg_w = (32'(scan_q) < STORE_DIGITS) ? store_q[scan_q] : '0;
		if (scan_q == POINT_POS) begin
			tick_seg_w = tick_seg_w | POINT_BIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
			scan_q      <= '0;
			for (int i = 0; i < STORE_DIGITS; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (mv1) begin
				valid_s1 <= 1'b0;
			end
			if (mv1) begin
				valid_s2 <= 1'b1;
			end else if (mv2) begin
				valid_s2 <= 1'b0;
			end
			if (mv2) begin
				valid_s3 <= 1'b1;
			end else if (mv3) begin
				valid_s3 <= 1'b0;
			end
			if (mv3) begin
				valid_s4 <= 1'b1;
			end else if (mv4) begin
				valid_s4 <= 1'b0;
			end
			if (commit_tick) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit_sample) begin
				store_q[0] <= neg_s4 ? MINUS_PATTERN : '0;
				store_q[1] <= seg_code(thou_s4);
				store_q[2] <= seg_code(hund_s4);
				store_q[3] <= seg_code(tens_w.digit);
				store_q[4] <= seg_code(tens_w.rem[3:0]);
				scan_q     <= '0;
			end else if (commit_tick) begin
				scan_q <= wrap_w ? '0 : pos_inc_w[POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= item.op;
			raw_s1 <= item.raw_temp;
		end
		if (mv1) begin
			op_s2  <= op_s1;
			neg_s2 <= neg_w;
			v_s2   <= v_w;
		end
		if (mv2) begin
			op_s3   <= op_s2;
			neg_s3  <= neg_s2;
			thou_s3 <= thou_w.digit;
			rem_s3  <= thou_w.rem;
		end
		if (mv3) begin
			op_s4   <= op_s3;
			neg_s4  <= neg_s3;
			thou_s4 <= thou_s3;
			hund_s4 <= hund_w.digit;
			rem_s4  <= hund_w.rem;
		end
		if (commit_tick) begin
			seg_q  <= tick_seg_w;
			dsel_q <= 3'd7 - scan_q;
			spos_q <= scan_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.segments      = seg_q;
	assign result.digit_select  = dsel_q;
	assign result.scan_position = spos_q;

	`TSD_ASSERT_IMP(a_scan_range, clk, arst_n, 1'b1, 32'(scan_q) < SCAN_DIGITS)
	`TSD_ASSERT_NXT(a_sample_rewinds, clk, arst_n, commit_sample, scan_q == '0)
	`TSD_ASSERT_IMP(a_point_place, clk, arst_n, result.valid,
		result.segments[7] == (result.scan_position == POINT_POS))
	`TSD_ASSERT_NXT(a_tick_shown, clk, arst_n, commit_tick,
		result.valid && result.scan_position == $past(scan_q))

endmodule
`default_nettype wire

[sim/temperature_seven_segment_display_unit_test.sv]
`timescale 1ns / 100ps
module temperature_seven_segment_display_unit_test;
	import tsd_pkg::*;

	typedef struct {
		seg_t segments;
		pos_t digit_select;
		pos_t scan_position;
	} digit_view_t;

	logic clk;
	logic arst_n;

	tsd_item_if   item_ch ();
	tsd_result_if result_ch ();

	temperature_seven_segment_display_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	seg_t digit_glyph [10] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
		8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};

	seg_t        shown_pattern [SCAN_DIGITS_DEF];
	pos_t        scan_at;
	digit_view_t awaited_digits [$];

	bit item_idle_on;
	bit result_stall_on;
	int fail_count;
	int sample_count;
	int tick_count;
	int digits_checked;

	// display state after one accepted transaction; a tick queues the digit it shows
	function automatic void advance_display(input op_t op, input temp_t reading);
		logic [11:0] bits;
		int          mag;
		int          hundredths;
		digit_view_t view;
		bits = reading;
		if (op == OP_SAMPLE) begin
			mag        = bits[11] ? 4096 - int'(bits) : int'(bits);
			hundredths = ((25 * mag + 2) / 4) % int'(MOD_VALUE);
			shown_pattern[0] = bits[11] ? MINUS_PATTERN : 8'h00;
			shown_pattern[1] = digit_glyph[(hundredths / 1000) % 10];
			shown_pattern[2] = digit_glyph[(hundredths / 100) % 10];
			shown_pattern[3] = digit_glyph[(hundredths / 10) % 10];
			shown_pattern[4] = digit_glyph[hundredths % 10];
			scan_at = '0;
			sample_count++;
		end else begin
			view.segments = (int'(scan_at) < STORE_DIGITS) ? shown_pattern[scan_at] : 8'h00;
			if (scan_at == POINT_POS) begin
				view.segments = view.segments | POINT_BIT;
			end
			view.digit_select  = 3'd7 - scan_at;
			view.scan_position = scan_at;
			awaited_digits.push_back(view);
			scan_at = (int'(scan_at) + 1 >= SCAN_DIGITS_DEF) ? pos_t'(0) : scan_at + 3'd1;
			tick_count++;
		end
	endfunction

	function automatic temp_t random_reading();
		temp_t corner [7] = '{-12'sd2048, 12'sd2047, 12'sd0, -12'sd1, 12'sd1,
			12'sd1600, -12'sd1600};
		if ($urandom_range(99) < 15) begin
			return corner[$urandom_range(6)];
		end
		return temp_t'($urandom_range(4095));
	endfunction

	task automatic send_transaction(input op_t op, input temp_t reading);
		while (item_idle_on && $urandom_range(99) < 36) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid    <= 1'b1;
		item_ch.op       <= op;
		item_ch.raw_temp <= reading;
		do @(posedge clk); while (!item_ch.ready);
		advance_display(op, reading);
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_transaction(OP_TICK, temp_t'($urandom));
	endtask

	task automatic send_sample(input temp_t reading);
		send_transaction(OP_SAMPLE, reading);
	endtask

	task automatic check_digit();
		digit_view_t want;
		if (awaited_digits.size() == 0) begin
			$error("unexpected result transaction: segments %h position %0d",
				result_ch.segments, result_ch.scan_position);
			fail_count++;
			return;
		end
		want = awaited_digits.pop_front();
		digits_checked++;
		if (result_ch.segments !== want.segments) begin
			$error("segments: expected %h, actual %h", want.segments, result_ch.segments);
			fail_count++;
		end
		if (result_ch.digit_select !== want.digit_select) begin
			$error("digit_select: expected %0d, actual %0d",
				want.digit_select, result_ch.digit_select);
			fail_count++;
		end
		if (result_ch.scan_position !== want.scan_position) begin
			$error("scan_position: expected %0d, actual %0d",
				want.scan_position, result_ch.scan_position);
			fail_count++;
		end
	endtask

	task automatic run_scan_sequences(input int count);
		int sent;
		int ticks;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 85) begin
				ticks = $urandom_range(8, 1);
				send_sample(random_reading());
				repeat (ticks) send_tick();
				sent += ticks + 1;
			end else if ($urandom_range(1) == 0) begin
				send_sample(random_reading());
				sent++;
			end else begin
				send_tick();
				sent++;
			end
		end
	endtask

	// reset store is blank, point only at position 2; sixth tick wraps, seventh shows position 0
	task automatic test_blank_after_reset();
		repeat (7) send_tick();
	endtask

	task automatic test_directed_readings();
		send_sample(-12'sd2048);
		repeat (6) send_tick();
		send_sample(12'sd2047);
		repeat (3) send_tick();
		send_sample(-12'sd1);
		repeat (2) send_tick();
		send_sample(12'sd1600);
		send_tick();
		send_sample(12'sd8);
		repeat (3) send_tick();
	endtask

	task automatic test_throttled_scans();
		item_idle_on    = 1'b1;
		result_stall_on = 1'b1;
		run_scan_sequences(480);
	endtask

	task automatic test_streaming_scans();
		item_idle_on    = 1'b0;
		result_stall_on = 1'b0;
		run_scan_sequences(200);
		item_idle_on    = 1'b1;
		result_stall_on = 1'b1;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= !(result_stall_on && $urandom_range(99) < 36);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			check_digit();
		end
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		item_ch.valid    = 1'b0;
		item_ch.op       = OP_SAMPLE;
		item_ch.raw_temp = '0;
		item_idle_on     = 1'b1;
		result_stall_on  = 1'b1;
		fail_count       = 0;
		sample_count     = 0;
		tick_count       = 0;
		digits_checked   = 0;
		scan_at          = '0;
		foreach (shown_pattern[i]) shown_pattern[i] = 8'h00;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_blank_after_reset();
		test_directed_readings();
		test_throttled_scans();
		test_streaming_scans();

		item_ch.valid <= 1'b0;
		while (awaited_digits.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d temperature samples and %0d scan ticks, %0d digits compared,",
			sample_count, tick_count, digits_checked);
		$display("with random and zero back-pressure on both channels.");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/tsd_pkg.sv
hw/rtl/tsd_if.sv
hw/rtl/temperature_seven_segment_display_unit.sv
sim/temperature_seven_segment_display_unit_test.sv
